@@ hdl/lpnti_pkg.sv @@
// types and constants shared by the name table indexer modules
`timescale 1ns / 1ps

package lpnti_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned INDEX_W  = 15;
    localparam int unsigned ORD_W    = 16;
    localparam int unsigned REASON_W = 2;
    localparam int unsigned TDATA_W  = 64;

    // ordinal bytes that follow the name text
    localparam int unsigned ORD_BYTES = 2;

    typedef enum logic [2:0] {
        PH_LENGTH = 3'd0,
        PH_TEXT   = 3'd1,
        PH_ORD_LO = 3'd2,
        PH_ORD_HI = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic {
        KIND_ENTRY = 1'b0,
        KIND_END   = 1'b1
    } record_kind_t;

    typedef enum logic [REASON_W-1:0] {
        END_FENCE   = 2'd0,
        END_ZERO    = 2'd1,
        END_OVERRUN = 2'd2
    } end_reason_t;

    typedef struct packed {
        record_kind_t               record_kind;
        logic [INDEX_W-1:0]         entry_index;
        logic [POS_W-1:0]           name_offset;
        logic [BYTE_W-1:0]          name_length;
        logic [ORD_W-1:0]           ordinal;
        end_reason_t                end_reason;
        logic                       final_entry;
    } record_t;

endpackage

@@ hdl/lpnti_parser.sv @@
// table parser: walks the entry layout one byte per beat and builds records
`timescale 1ns / 1ps

module lpnti_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [lpnti_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          restart,
    input  logic [lpnti_pkg::POS_W-1:0]   table_length,
    output logic                          rec_valid,
    output lpnti_pkg::record_t            rec
);
    import lpnti_pkg::*;

    localparam int unsigned SUM_W = POS_W + 2;

    phase_t               phase_reg,     phase_next;
    logic [POS_W-1:0]     position_reg,  position_next;
    logic [BYTE_W-1:0]    remain_reg,    remain_next;
    logic [INDEX_W-1:0]   count_reg,     count_next;
    logic [POS_W-1:0]     offset_reg,    offset_next;
    logic [BYTE_W-1:0]    length_reg,    length_next;
    logic [BYTE_W-1:0]    ord_lo_reg,    ord_lo_next;

    // state as seen after an optional restart clear
    phase_t               eff_phase;
    logic [POS_W-1:0]     here;
    logic [BYTE_W-1:0]    eff_remain;
    logic [INDEX_W-1:0]   eff_count;
    logic [POS_W-1:0]     eff_offset;
    logic [BYTE_W-1:0]    eff_length;
    logic [BYTE_W-1:0]    eff_ord_lo;
    logic [POS_W-1:0]     here_inc;
    logic [SUM_W-1:0]     entry_end;
    logic [BYTE_W-1:0]    remain_dec;

    always_comb begin
        eff_phase  = restart ? PH_LENGTH : phase_reg;
        here       = restart ? '0 : position_reg;
        eff_remain = restart ? '0 : remain_reg;
        eff_count  = restart ? '0 : count_reg;
        eff_offset = restart ? '0 : offset_reg;
        eff_length = restart ? '0 : length_reg;
        eff_ord_lo = restart ? '0 : ord_lo_reg;

        here_inc   = here + POS_W'(1);
        entry_end  = SUM_W'(here) + SUM_W'(data_byte) + SUM_W'(1 + ORD_BYTES);
        remain_dec = eff_remain - BYTE_W'(1);

        phase_next    = eff_phase;
        position_next = here;
        remain_next   = eff_remain;
        count_next    = eff_count;
        offset_next   = eff_offset;
        length_next   = eff_length;
        ord_lo_next   = eff_ord_lo;

        rec_valid       = 1'b0;
        rec             = '0;
        rec.record_kind = KIND_END;
        rec.entry_index = eff_count;

        case (eff_phase)
            PH_LENGTH: begin
                if (here >= table_length) begin
                    rec_valid      = 1'b1;
                    rec.end_reason = END_FENCE;
                    phase_next     = PH_DONE;
                end else if (data_byte == '0) begin
                    rec_valid      = 1'b1;
                    rec.end_reason = END_ZERO;
                    phase_next     = PH_DONE;
                end else if (entry_end > SUM_W'(table_length)) begin
                    rec_valid      = 1'b1;
                    rec.end_reason = END_OVERRUN;
                    phase_next     = PH_DONE;
                end else begin
                    length_next   = data_byte;
                    offset_next   = here_inc;
                    remain_next   = data_byte;
                    phase_next    = PH_TEXT;
                    position_next = here_inc;
                end
            end
            PH_TEXT: begin
                remain_next   = remain_dec;
                position_next = here_inc;
                if (remain_dec == '0) begin
                    phase_next = PH_ORD_LO;
                end
            end
            PH_ORD_LO: begin
                ord_lo_next   = data_byte;
                phase_next    = PH_ORD_HI;
                position_next = here_inc;
            end
            PH_ORD_HI: begin
                rec_valid       = 1'b1;
                rec.record_kind = KIND_ENTRY;
                rec.name_offset = eff_offset;
                rec.name_length = eff_length;
                rec.ordinal     = {data_byte, eff_ord_lo};
                rec.end_reason  = END_FENCE;
                rec.final_entry = (here_inc == table_length);
                count_next      = eff_count + INDEX_W'(1);
                position_next   = here_inc;
                phase_next      = PH_LENGTH;
            end
            default: begin
                // finished table: bytes are dropped until a restart
            end
        endcase

        if (!step) begin
            rec_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LENGTH;
            position_reg <= '0;
            remain_reg   <= '0;
            count_reg    <= '0;
            offset_reg   <= '0;
            length_reg   <= '0;
            ord_lo_reg   <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            position_reg <= position_next;
            remain_reg   <= remain_next;
            count_reg    <= count_next;
            offset_reg   <= offset_next;
            length_reg   <= length_next;
            ord_lo_reg   <= ord_lo_next;
        end
    end

endmodule

@@ hdl/lpnti_out_buf.sv @@
// two-entry output buffer: result register plus skid register
`timescale 1ns / 1ps

module lpnti_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lpnti_pkg::record_t  push_rec,
    output logic                can_push,
    output logic                out_valid,
    output lpnti_pkg::record_t  out_rec,
    input  logic                out_ready
);
    import lpnti_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    record_t   main_rec_reg,   main_rec_next;
    record_t   skid_rec_reg,   skid_rec_next;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_rec_next   = main_rec_reg;
        skid_rec_next   = skid_rec_reg;

        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_rec_next   = skid_rec_reg;
                skid_valid_next = push;
                skid_rec_next   = push_rec;
            end else begin
                main_valid_next = push;
                main_rec_next   = push_rec;
            end
        end else if (push) begin
            // main beat stalled, park the new one
            skid_valid_next = 1'b1;
            skid_rec_next   = push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_rec_reg <= main_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_rec   = main_rec_reg;

endmodule

@@ hdl/length_prefixed_name_table_indexer.sv @@
// top level of the length-prefixed name table indexer
`timescale 1ns / 1ps

// usage
//   slave side takes the raw table one byte per beat in s_tdata; s_tuser high
//   marks the first byte of a new table and clears all parse state first
//   each entry is a length byte, the name text and a little-endian ordinal;
//   the beat carrying the ordinal high byte yields an entry record, and a
//   zero length byte, a length byte at or past the fence, or an entry that
//   would overrun the fence yields an end record (m_tuser high); after that
//   bytes are dropped until the next restart beat
//   master side: one record per beat, m_tlast flags an entry ending exactly
//   at table_length
//   cfg_wr_en / cfg_wr_data write table_length; write it between tables
// timing
//   one byte per cycle sustained while s_tready is high; a record is held
//   in the result register, or the skid register while m_tready stalls;
//   parser decode and buffer select are the only logic before that register
// reset and stall
//   aresetn (synchronous, active low) clears table_length, parse state and
//   the output buffer; a stalled m_tready is absorbed by one skid entry, and
//   s_tready drops only while that skid entry is full
module length_prefixed_name_table_indexer (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration: table_length
    input  logic                              cfg_wr_en,
    input  logic [lpnti_pkg::POS_W-1:0]       cfg_wr_data,
    // byte input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lpnti_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] data_byte
    input  logic                              s_tuser,   // restart
    // record output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [14:0] entry_index, [30:15] name_offset, [38:31] name_length,
    // [54:39] ordinal, [56:55] end_reason, [63:57] zero
    output logic [lpnti_pkg::TDATA_W-1:0]     m_tdata,
    output logic                              m_tuser,   // record_kind
    output logic                              m_tlast    // final_entry
);
    import lpnti_pkg::*;

    localparam int unsigned PAYLOAD_W = INDEX_W + POS_W + BYTE_W + ORD_W + REASON_W;

    logic [POS_W-1:0] table_length_reg;
    logic             step;
    logic             rec_valid;
    record_t          rec;
    record_t          out_rec;

    // fence register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_length_reg <= '0;
        end else if (cfg_wr_en) begin
            table_length_reg <= cfg_wr_data;
        end
    end

    assign step = s_tvalid && s_tready;

    lpnti_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .data_byte    (s_tdata),
        .restart      (s_tuser),
        .table_length (table_length_reg),
        .rec_valid    (rec_valid),
        .rec          (rec)
    );

    lpnti_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_valid),
        .push_rec  (rec),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_rec   (out_rec),
        .out_ready (m_tready)
    );

    // pack record fields, lowest first, zero fill to whole bytes
    assign m_tdata = {
        (TDATA_W - PAYLOAD_W)'(0),
        out_rec.end_reason,
        out_rec.ordinal,
        out_rec.name_length,
        out_rec.name_offset,
        out_rec.entry_index
    };
    assign m_tuser = out_rec.record_kind;
    assign m_tlast = out_rec.final_entry;

endmodule
